// ----- rtl/core/pcss_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and lookup functions for the pulse counter segment scan.
// Used by pcss_serial_div and pulse_counter_segment_scan_top; depends on nothing.

package pcss_pkg;

    localparam int COUNT_W       = 14;
    localparam int COUNT_MODULUS = 10000;
    localparam int SEGMENT_LINES = 7;
    localparam int BASE_W        = 5;
    localparam int DIGIT_W       = 4;
    localparam int SEG_W         = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(9995 % COUNT_MODULUS);
    localparam logic [COUNT_W-1:0] COUNT_LAST  = COUNT_W'(COUNT_MODULUS - 1);
    localparam logic [BASE_W-1:0]  BASE_RESET  = BASE_W'(10);
    localparam logic [BASE_W-1:0]  BASE_MIN    = BASE_W'(2);
    localparam logic [BASE_W-1:0]  BASE_MAX    = BASE_W'(16);

    // Status handed from the serial divider to the scanner.
    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] quotient;
        logic [DIGIT_W-1:0] remainder;
    } t_div_stat;

    typedef struct packed {
        logic             found;
        logic [SEG_W-1:0] idx;
    } t_find;

    // Active-low segment patterns, one per digit value.
    function automatic logic [7:0] seg_code(input logic [DIGIT_W-1:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'h0: code = 8'h82;
            4'h1: code = 8'hbb;
            4'h2: code = 8'h85;
            4'h3: code = 8'h91;
            4'h4: code = 8'hb8;
            4'h5: code = 8'hd0;
            4'h6: code = 8'hc0;
            4'h7: code = 8'h9b;
            4'h8: code = 8'h80;
            4'h9: code = 8'h90;
            4'ha: code = 8'h88;
            4'hb: code = 8'he0;
            4'hc: code = 8'hc6;
            4'hd: code = 8'ha1;
            4'he: code = 8'hc4;
            4'hf: code = 8'hcc;
        endcase
        return code;
    endfunction

    // Lowest lit (zero) segment line at or after start.
    function automatic t_find find_lit(input logic [7:0] code, input logic [SEG_W:0] start);
        t_find res;
        res = '0;
        for (int i = SEGMENT_LINES - 1; i >= 0; i--) begin
            if ((SEG_W+1)'(i) >= start && !code[i]) begin
                res.found = 1'b1;
                res.idx   = SEG_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/pulse_counter_segment_scan_top.sv -----
`timescale 1ns / 1ps
// Pulse counter with multiplexed seven-segment scan, one display tick per item.
// Depends on pcss_pkg and pcss_serial_div.

// One item per display tick: a set pulse advances the count (wrapping at the count
// modulus), and one result names the lit segment to drive this tick, or blank when the
// count is zero. Digits come from the count by repeated division by the configured base
// (clamped to 2..16), least significant first, with no leading zeros. Each digit comes
// from a 14-step bit-serial divide by the base; each move on to the next digit, before
// or after the segment shown, costs one more divide. A blank tick skips the divider.
// The next item is accepted while a finished result still waits on the output; a result
// that cannot leave holds the block in its last step.

module pulse_counter_segment_scan_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pcss_pkg::BASE_W-1:0]  i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_pulse,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pcss_pkg::DIGIT_W-1:0] o_digit_position,
    output logic [pcss_pkg::SEG_W-1:0]   o_segment_index,
    output logic                         o_segment_lit,
    output logic [pcss_pkg::COUNT_W-1:0] o_count_value
);

    typedef enum logic [2:0] {S_IDLE, S_LOAD, S_DIV, S_FIND, S_POST, S_OUT} t_state;

    t_state                         r_state;
    logic [pcss_pkg::BASE_W-1:0]    r_base;
    logic [pcss_pkg::COUNT_W-1:0]   r_count;
    logic [pcss_pkg::COUNT_W-1:0]   r_rem;
    logic [pcss_pkg::DIGIT_W-1:0]   r_digit;
    logic [pcss_pkg::SEG_W-1:0]     r_seg;
    logic                           r_seek;
    logic [pcss_pkg::DIGIT_W-1:0]   r_res_digit;
    logic [pcss_pkg::SEG_W-1:0]     r_res_seg;
    logic                           r_res_lit;
    logic                           r_o_valid;
    logic [pcss_pkg::DIGIT_W-1:0]   r_o_digit;
    logic [pcss_pkg::SEG_W-1:0]     r_o_seg;
    logic                           r_o_lit;
    logic [pcss_pkg::COUNT_W-1:0]   r_o_count;

    logic [pcss_pkg::BASE_W-1:0]    w_base;
    logic [pcss_pkg::COUNT_W-1:0]   w_load_val;
    logic [7:0]                     w_code;
    pcss_pkg::t_find                w_find_cur;
    pcss_pkg::t_find                w_find_next;
    logic                           w_div_start;
    logic [pcss_pkg::COUNT_W-1:0]   w_div_in;
    pcss_pkg::t_div_stat            w_div;
    logic                           w_in_acc;
    logic                           w_out_free;

    always_comb begin
        priority if (r_base < pcss_pkg::BASE_MIN) begin
            w_base = pcss_pkg::BASE_MIN;
        end else if (r_base > pcss_pkg::BASE_MAX) begin
            w_base = pcss_pkg::BASE_MAX;
        end else begin
            w_base = r_base;
        end
        w_load_val  = (r_rem == '0) ? r_count : r_rem;
        w_code      = pcss_pkg::seg_code(w_div.remainder);
        w_find_cur  = pcss_pkg::find_lit(w_code, {1'b0, r_seg});
        w_find_next = pcss_pkg::find_lit(w_code, {1'b0, r_seg} + (pcss_pkg::SEG_W+1)'(1));
        w_div_start = 1'b0;
        w_div_in    = w_load_val;
        if (r_state == S_LOAD && w_load_val != '0) begin
            w_div_start = 1'b1;
        end
        if (r_state == S_FIND && !w_find_cur.found && w_div.quotient != '0) begin
            w_div_start = 1'b1;
            w_div_in    = w_div.quotient;
        end
        if (r_state == S_POST && !w_find_next.found && w_div.quotient != '0) begin
            w_div_start = 1'b1;
            w_div_in    = w_div.quotient;
        end
        w_in_acc   = i_valid && o_ready;
        w_out_free = !r_o_valid || i_ready;
    end

    pcss_serial_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_in),
        .i_divisor  (w_base),
        .o_stat     (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_base    <= pcss_pkg::BASE_RESET;
            r_count   <= pcss_pkg::COUNT_RESET;
            r_rem     <= '0;
            r_digit   <= '0;
            r_seg     <= '0;
            r_seek    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_base <= i_cfg_data;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_pulse) begin
                            r_count <= (r_count == pcss_pkg::COUNT_LAST) ? '0
                                     : r_count + pcss_pkg::COUNT_W'(1);
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_seek <= 1'b0;
                    // take a fresh snapshot once the previous one is used up
                    if (r_rem == '0) begin
                        r_rem   <= r_count;
                        r_digit <= '0;
                        r_seg   <= '0;
                    end
                    if (w_load_val == '0) begin
                        r_res_lit   <= 1'b0;
                        r_res_digit <= '0;
                        r_res_seg   <= '0;
                        r_state     <= S_OUT;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div.done) begin
                        r_state <= S_FIND;
                    end
                end
                S_FIND: begin
                    if (w_find_cur.found) begin
                        r_seg <= w_find_cur.idx;
                        if (r_seek) begin
                            // park on the first lit segment of the next digit
                            r_state <= S_OUT;
                        end else begin
                            r_res_lit   <= 1'b1;
                            r_res_digit <= r_digit;
                            r_res_seg   <= w_find_cur.idx;
                            r_state     <= S_POST;
                        end
                    end else begin
                        // digit shows nothing more: drop it and move to the next one
                        r_rem   <= w_div.quotient;
                        r_digit <= r_digit + pcss_pkg::DIGIT_W'(1);
                        r_seg   <= '0;
                        if (w_div.quotient == '0) begin
                            if (!r_seek) begin
                                r_res_lit   <= 1'b0;
                                r_res_digit <= '0;
                                r_res_seg   <= '0;
                            end
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_POST: begin
                    // step past the shown segment; on a new digit, divide again with
                    // this base to find its first lit segment
                    if (w_find_next.found) begin
                        r_seg   <= w_find_next.idx;
                        r_state <= S_OUT;
                    end else begin
                        r_rem   <= w_div.quotient;
                        r_digit <= r_digit + pcss_pkg::DIGIT_W'(1);
                        r_seg   <= '0;
                        if (w_div.quotient == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_seek  <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_o_digit <= r_res_digit;
                        r_o_seg   <= r_res_seg;
                        r_o_lit   <= r_res_lit;
                        r_o_count <= r_count;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_digit_position = r_o_digit;
    assign o_segment_index  = r_o_seg;
    assign o_segment_lit    = r_o_lit;
    assign o_count_value    = r_o_count;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken while an item is still in progress");

    a_blank_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_segment_lit) |-> (o_digit_position == '0 && o_segment_index == '0))
        else $error("blank result carries a digit or segment");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_count_value <= pcss_pkg::COUNT_LAST))
        else $error("count value beyond modulus");

endmodule

// ----- rtl/core/pcss_serial_div.sv -----
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle, narrow partial remainder.
// Depends on pcss_pkg.

module pcss_serial_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pcss_pkg::COUNT_W-1:0] i_dividend,
    input  logic [pcss_pkg::BASE_W-1:0]  i_divisor,
    output pcss_pkg::t_div_stat          o_stat
);

    localparam int CNT_W = $clog2(pcss_pkg::COUNT_W + 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [pcss_pkg::COUNT_W-1:0]  r_q;
    logic [pcss_pkg::DIGIT_W-1:0]  r_r;
    logic [pcss_pkg::BASE_W-1:0]   r_d;

    logic [pcss_pkg::DIGIT_W:0]    w_trial;
    logic                          w_ge;
    logic [pcss_pkg::DIGIT_W-1:0]  n_r;

    always_comb begin
        // shift the next dividend bit into the partial remainder
        w_trial = {r_r, r_q[pcss_pkg::COUNT_W-1]};
        w_ge    = (w_trial >= r_d);
        n_r     = w_ge ? pcss_pkg::DIGIT_W'(w_trial - r_d) : w_trial[pcss_pkg::DIGIT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= '0;
            r_r    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(pcss_pkg::COUNT_W);
            r_q    <= i_dividend;
            r_r    <= '0;
            r_d    <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[pcss_pkg::COUNT_W-2:0], w_ge};
            r_r   <= n_r;
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.quotient  = r_q;
    assign o_stat.remainder = r_r;

endmodule

// ----- test/segment_scan_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the pulse counter segment scan: watches config writes and both item
// channels, predicts each display tick and compares every result field. Needs pcss_pkg.

module segment_scan_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [pcss_pkg::BASE_W-1:0]  i_cfg_data,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  logic                         i_pulse,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  logic [pcss_pkg::DIGIT_W-1:0] i_digit_position,
    input  logic [pcss_pkg::SEG_W-1:0]   i_segment_index,
    input  logic                         i_segment_lit,
    input  logic [pcss_pkg::COUNT_W-1:0] i_count_value,
    output int                           o_failures,
    output int                           o_outstanding
);

    typedef struct packed {
        logic [pcss_pkg::DIGIT_W-1:0] digit;
        logic [pcss_pkg::SEG_W-1:0]   segment;
        logic                         lit;
        logic [pcss_pkg::COUNT_W-1:0] count;
    } t_scan_result;

    // Active-low segment patterns per digit value.
    localparam logic [7:0] DIGIT_GLYPH [16] = '{
        8'h82, 8'hbb, 8'h85, 8'h91, 8'hb8, 8'hd0, 8'hc0, 8'h9b,
        8'h80, 8'h90, 8'h88, 8'he0, 8'hc6, 8'ha1, 8'hc4, 8'hcc
    };

    t_scan_result                 expected_scans[$];
    logic [pcss_pkg::BASE_W-1:0]  radix_reg;
    logic [pcss_pkg::COUNT_W-1:0] pulse_tally;
    logic [pcss_pkg::COUNT_W-1:0] snapshot_left;
    logic [pcss_pkg::DIGIT_W-1:0] scan_digit_pos;
    int unsigned                  scan_seg_pos;

    initial o_failures = 0;
    initial o_outstanding = 0;

    function automatic int unsigned active_radix();
        if (radix_reg < pcss_pkg::BASE_MIN) return 32'(pcss_pkg::BASE_MIN);
        if (radix_reg > pcss_pkg::BASE_MAX) return 32'(pcss_pkg::BASE_MAX);
        return 32'(radix_reg);
    endfunction

    // Move to the next lit segment at or after the scan position, crossing digits.
    task automatic seek_lit_segment();
        int unsigned r;
        logic [7:0]  glyph;
        bit          hit;
        r   = active_radix();
        hit = 1'b0;
        while (snapshot_left != 0 && !hit) begin
            glyph = DIGIT_GLYPH[4'(snapshot_left % r)];
            for (int i = scan_seg_pos; i < pcss_pkg::SEGMENT_LINES; i++) begin
                if (!hit && !glyph[i]) begin
                    scan_seg_pos = i;
                    hit          = 1'b1;
                end
            end
            if (!hit) begin
                snapshot_left  = pcss_pkg::COUNT_W'(snapshot_left / r);
                scan_digit_pos = scan_digit_pos + 1'b1;
                scan_seg_pos   = 0;
            end
        end
    endtask

    task automatic predict_tick(input logic pulse);
        t_scan_result r;
        if (pulse)
            pulse_tally = pcss_pkg::COUNT_W'((int'(pulse_tally) + 1)
                                             % pcss_pkg::COUNT_MODULUS);
        if (snapshot_left == 0) begin
            snapshot_left  = pulse_tally;
            scan_digit_pos = '0;
            scan_seg_pos   = 0;
        end
        seek_lit_segment();
        if (snapshot_left == 0) begin
            r.digit   = '0;
            r.segment = '0;
            r.lit     = 1'b0;
        end else begin
            r.digit   = scan_digit_pos;
            r.segment = pcss_pkg::SEG_W'(scan_seg_pos);
            r.lit     = 1'b1;
            scan_seg_pos++;
            seek_lit_segment();
        end
        r.count = pulse_tally;
        expected_scans.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $realtime, msg);
        o_failures++;
    endtask

    task automatic compare_result();
        t_scan_result want;
        if (expected_scans.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected (count_value %0d)",
                                      i_count_value));
            return;
        end
        want = expected_scans.pop_front();
        if (i_digit_position !== want.digit)
            report_mismatch($sformatf("digit_position %0d, expected %0d",
                                      i_digit_position, want.digit));
        if (i_segment_index !== want.segment)
            report_mismatch($sformatf("segment_index %0d, expected %0d",
                                      i_segment_index, want.segment));
        if (i_segment_lit !== want.lit)
            report_mismatch($sformatf("segment_lit %0d, expected %0d",
                                      i_segment_lit, want.lit));
        if (i_count_value !== want.count)
            report_mismatch($sformatf("count_value %0d, expected %0d",
                                      i_count_value, want.count));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            radix_reg      = pcss_pkg::BASE_RESET;
            pulse_tally    = pcss_pkg::COUNT_RESET;
            snapshot_left  = '0;
            scan_digit_pos = '0;
            scan_seg_pos   = 0;
            expected_scans.delete();
        end else begin
            if (i_cfg_we)
                radix_reg = i_cfg_data;
            // Check the output first: a result never leaves in the cycle its item enters.
            if (i_out_valid && i_out_ready)
                compare_result();
            if (i_in_valid && i_in_ready)
                predict_tick(i_pulse);
        end
        o_outstanding <= expected_scans.size();
    end

endmodule

// ----- test/tb_pulse_counter_segment_scan_top.sv -----
`timescale 1ns / 1ps
// Testbench top for pulse_counter_segment_scan_top: clock, reset, tick stimulus, output
// stalls and verdict. Needs pcss_pkg, the block and segment_scan_checker.

module tb_pulse_counter_segment_scan_top;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} t_idle_mode;

    localparam int TX_GAP_PCT    = 61;
    localparam int RX_STALL_PCT  = 61;
    localparam int BOTH_IDLE_PCT = 25;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_CYCLES  = 60;
    localparam int STALL_LIMIT   = 3000;
    localparam int PHASES        = 12;
    localparam int PHASE_TICKS   = 104;

    logic                         i_clk            = 1'b0;
    logic                         i_rst_n          = 1'b0;
    logic                         i_cfg_we         = 1'b0;
    logic [pcss_pkg::BASE_W-1:0]  i_cfg_data       = '0;
    logic                         i_valid          = 1'b0;
    logic                         i_pulse          = 1'b0;
    logic                         i_ready          = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic [pcss_pkg::DIGIT_W-1:0] o_digit_position;
    logic [pcss_pkg::SEG_W-1:0]   o_segment_index;
    logic                         o_segment_lit;
    logic [pcss_pkg::COUNT_W-1:0] o_count_value;

    t_idle_mode idle_mode = IDLE_NONE;
    logic       hold_req  = 1'b0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    int         failures;
    int         outstanding;

    pulse_counter_segment_scan_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pulse          (i_pulse),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_digit_position (o_digit_position),
        .o_segment_index  (o_segment_index),
        .o_segment_lit    (o_segment_lit),
        .o_count_value    (o_count_value)
    );

    segment_scan_checker scoreboard (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_ready       (o_ready),
        .i_pulse          (i_pulse),
        .i_out_valid      (o_valid),
        .i_out_ready      (i_ready),
        .i_digit_position (o_digit_position),
        .i_segment_index  (o_segment_index),
        .i_segment_lit    (o_segment_lit),
        .i_count_value    (o_count_value),
        .o_failures       (failures),
        .o_outstanding    (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Output side: long hold on request, otherwise stall by the phase's idle mode.
    always @(posedge i_clk) begin
        if (hold_req)
            hold_left = LONG_HOLD;
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RX:   i_ready <= ($urandom_range(99) >= RX_STALL_PCT);
                IDLE_BOTH: i_ready <= ($urandom_range(99) >= BOTH_IDLE_PCT);
                default:   i_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_tick(input logic pulse);
        int gap_pct;
        case (idle_mode)
            IDLE_TX:   gap_pct = TX_GAP_PCT;
            IDLE_BOTH: gap_pct = BOTH_IDLE_PCT;
            default:   gap_pct = 0;
        endcase
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_valid <= 1'b1;
        i_pulse <= pulse;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and hold off until every expected result has come out.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [pcss_pkg::BASE_W-1:0] value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [pcss_pkg::BASE_W-1:0] radix;
        int                          pulse_pct;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: base below range (acts as binary) on the reset count, wrap 9999 -> 0,
        // then the first ticks of a long binary scan, which phase 0 runs on to the top digit.
        write_radix(pcss_pkg::BASE_W'(1));
        repeat (5) send_tick(1'b1);
        repeat (20) send_tick(1'b0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       radix = pcss_pkg::BASE_W'(1);
                1:       radix = pcss_pkg::BASE_MAX;
                2:       radix = pcss_pkg::BASE_MIN;
                3:       radix = '0;
                4:       radix = '1;
                5:       radix = pcss_pkg::BASE_W'(17);
                6:       radix = pcss_pkg::BASE_RESET;
                default: radix = pcss_pkg::BASE_W'($urandom_range(0, 31));
            endcase
            // Phase 0 keeps the directed base and the count at zero, so the binary scan
            // finishes and the display goes blank.
            if (p != 0)
                write_radix(radix);
            case (p)
                0:       pulse_pct = 0;
                2:       pulse_pct = 100;
                default: pulse_pct = $urandom_range(0, 100);
            endcase
            idle_mode <= t_idle_mode'(p % 4);
            if (p == 4) begin
                hold_req <= 1'b1;
                @(posedge i_clk);
                hold_req <= 1'b0;
            end
            for (int n = 0; n < PHASE_TICKS; n++)
                send_tick($urandom_range(99) < pulse_pct);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (failures == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/pcss_pkg.sv
rtl/core/pcss_serial_div.sv
rtl/core/pulse_counter_segment_scan_top.sv
test/segment_scan_checker.sv
test/tb_pulse_counter_segment_scan_top.sv
